[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the subkey derivation RTL. They are empty
// in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define HCC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define HCC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed during reset");
`else
`define HCC_ASSERT(lbl, prop)
`define HCC_ASSERT_RST(lbl, prop)
`endif

`endif

[hw/rtl/hcc_pkg.sv]
// ---------------------------------------------------------------------------
// hcc_pkg
// Types, constants and helper functions shared by the subkey derivation RTL.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hcc_pkg;

    localparam int WORD_W = 32;
    localparam int FIELD_W = 64;
    localparam int STATE_WORDS = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [WORD_W-1:0] SIGMA_0 = 32'h61707865;
    localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320646e;
    localparam logic [WORD_W-1:0] SIGMA_2 = 32'h79622d32;
    localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b206574;

    typedef logic [STATE_WORDS-1:0][WORD_W-1:0] t_state;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_0_7   = 2'd0,
        REG_KEY_8_15  = 2'd1,
        REG_KEY_16_23 = 2'd2,
        REG_KEY_24_31 = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [FIELD_W-1:0] nonce_bytes_8_15;
        logic [FIELD_W-1:0] nonce_bytes_0_7;
    } t_in_word;

    typedef struct packed {
        logic [FIELD_W-1:0] subkey_bytes_24_31;
        logic [FIELD_W-1:0] subkey_bytes_16_23;
        logic [FIELD_W-1:0] subkey_bytes_8_15;
        logic [FIELD_W-1:0] subkey_bytes_0_7;
    } t_out_word;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                 input logic [4:0] n);
        return (v << n) | (v >> (6'd32 - {1'b0, n}));
    endfunction

endpackage

`default_nettype wire

[hw/rtl/hchacha20_subkey_derivation.sv]
// ---------------------------------------------------------------------------
// hchacha20_subkey_derivation
// HChaCha20 subkey derivation as a chain of half-quarter-round cells.
// ---------------------------------------------------------------------------
// Usage:
// The 256-bit key is written as four 64-bit registers over the plain write
// port (i_cfg_we, i_cfg_index, i_cfg_data) while the block is idle.
// Each input word on the valid/ready input channel carries a 128-bit nonce;
// each output word carries the 256-bit subkey for that nonce, in order.
// The chain has 4 * DOUBLE_ROUNDS cells (40 for the default), each doing half
// of a quarter-round on all four columns or diagonals; a word passes through
// every cell register in order from acceptance to the result being shown.
// One word is accepted per cycle whenever the first cell is free.
// Every cell advances when it is empty or its neighbor advances, so bubbles
// close up while the receiver stalls; input ready drops only once the whole
// chain is full. The last cell is the output register.
// Reset clears all cell valid flags and sets the key registers to zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hchacha20_subkey_derivation #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire hcc_pkg::t_in_word                 i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output hcc_pkg::t_out_word                     o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [hcc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [hcc_pkg::FIELD_W-1:0]       i_cfg_data
);

    localparam int NUM_CELLS = 4 * DOUBLE_ROUNDS;

    logic [hcc_pkg::FIELD_W-1:0] r_key [4];

    logic            w_valid [NUM_CELLS+1];
    logic            w_ready [NUM_CELLS+1];
    hcc_pkg::t_state w_state [NUM_CELLS+1];
    hcc_pkg::t_state w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (hcc_pkg::t_cfg_reg'(i_cfg_index))
                hcc_pkg::REG_KEY_0_7:   r_key[0] <= i_cfg_data;
                hcc_pkg::REG_KEY_8_15:  r_key[1] <= i_cfg_data;
                hcc_pkg::REG_KEY_16_23: r_key[2] <= i_cfg_data;
                hcc_pkg::REG_KEY_24_31: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_state[0][0]  = hcc_pkg::SIGMA_0;
        w_state[0][1]  = hcc_pkg::SIGMA_1;
        w_state[0][2]  = hcc_pkg::SIGMA_2;
        w_state[0][3]  = hcc_pkg::SIGMA_3;
        w_state[0][4]  = r_key[0][31:0];
        w_state[0][5]  = r_key[0][63:32];
        w_state[0][6]  = r_key[1][31:0];
        w_state[0][7]  = r_key[1][63:32];
        w_state[0][8]  = r_key[2][31:0];
        w_state[0][9]  = r_key[2][63:32];
        w_state[0][10] = r_key[3][31:0];
        w_state[0][11] = r_key[3][63:32];
        w_state[0][12] = i_in_data.nonce_bytes_0_7[31:0];
        w_state[0][13] = i_in_data.nonce_bytes_0_7[63:32];
        w_state[0][14] = i_in_data.nonce_bytes_8_15[31:0];
        w_state[0][15] = i_in_data.nonce_bytes_8_15[63:32];
    end

    assign w_valid[0]         = i_in_valid;
    assign o_in_ready         = w_ready[0];
    assign w_ready[NUM_CELLS] = i_out_ready;
    assign o_out_valid        = w_valid[NUM_CELLS];
    assign w_last             = w_state[NUM_CELLS];

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        hcc_cell #(
            .DIAG   (1'((k / 2) % 2)),
            .SECOND (1'(k % 2))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_state (w_state[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_state (w_state[k+1])
        );
    end

    assign o_out_data.subkey_bytes_0_7   = {w_last[1], w_last[0]};
    assign o_out_data.subkey_bytes_8_15  = {w_last[3], w_last[2]};
    assign o_out_data.subkey_bytes_16_23 = {w_last[13], w_last[12]};
    assign o_out_data.subkey_bytes_24_31 = {w_last[15], w_last[14]};

    `HCC_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !o_out_valid)
    `HCC_ASSERT(a_accept_fills_first, (i_in_valid && o_in_ready) |=> w_valid[1])
    `HCC_ASSERT(a_free_first_ready, !w_valid[1] |-> o_in_ready)

endmodule

`default_nettype wire

[hw/rtl/hcc_cell.sv]
// ---------------------------------------------------------------------------
// hcc_cell
// One pipeline cell: half of a quarter-round applied to all four columns or
// all four diagonals of the state, registered, with valid/ready flow control.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcc_cell #(
    parameter bit DIAG   = 1'b0,
    parameter bit SECOND = 1'b0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire hcc_pkg::t_state i_state,
    output logic                o_valid,
    input  wire logic           i_ready,
    output hcc_pkg::t_state     o_state
);

    localparam int OFF = DIAG ? 1 : 0;
    localparam int ROT_A = SECOND ? 8 : 16;
    localparam int ROT_B = SECOND ? 7 : 12;

    logic            r_valid;
    hcc_pkg::t_state r_state;
    hcc_pkg::t_state n_state;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_state = r_state;

    always_comb begin
        logic [3:0]  ia;
        logic [3:0]  ib;
        logic [3:0]  ic;
        logic [3:0]  id;
        logic [31:0] a_sum;
        logic [31:0] d_rot;
        logic [31:0] c_sum;
        n_state = i_state;
        for (int j = 0; j < 4; j++) begin
            ia = {2'b00, 2'(j)};
            ib = {2'b01, 2'(j + OFF)};
            ic = {2'b10, 2'(j + 2 * OFF)};
            id = {2'b11, 2'(j + 3 * OFF)};
            a_sum = i_state[ia] + i_state[ib];
            d_rot = hcc_pkg::rotl32(i_state[id] ^ a_sum, 5'(ROT_A));
            c_sum = i_state[ic] + d_rot;
            n_state[ia] = a_sum;
            n_state[id] = d_rot;
            n_state[ic] = c_sum;
            n_state[ib] = hcc_pkg::rotl32(i_state[ib] ^ c_sum, 5'(ROT_B));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire
